@@ src/udmn_pkg.sv @@
package udmn_pkg;

	localparam int DataW  = 32;
	localparam int ShiftW = 6;
	localparam int PW     = 7;
	localparam int DivSteps = DataW;
	localparam int DivCntW  = $clog2(DivSteps);

	localparam logic [DataW-1:0] TopBit  = 32'h8000_0000;
	localparam logic [DataW-1:0] TopLess = 32'h7FFF_FFFF;
	localparam logic [PW-1:0]    PStart  = 7'd31;
	localparam logic [PW-1:0]    PLimit  = 7'd64;
	localparam logic [PW-1:0]    PBias   = 7'd32;

	// Request to the shared bit-serial divider.
	typedef struct packed {
		logic             start;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DataW-1:0] quot;
		logic [DataW-1:0] rem;
	} div_rsp_t;

	// Seed values and control for the refinement unit.
	typedef struct packed {
		logic             load;
		logic             release_res;
		logic [DataW-1:0] d;
		logic [DataW-1:0] nc;
		logic [DataW-1:0] q1;
		logic [DataW-1:0] r1;
		logic [DataW-1:0] q2;
		logic [DataW-1:0] r2;
	} ref_ctl_t;

	typedef struct packed {
		logic              done;
		logic [DataW-1:0]  mult;
		logic              addf;
		logic [ShiftW-1:0] shift;
	} ref_stat_t;

endpackage

@@ src/udmn_if.sv @@
interface udmn_in_if;
	logic                         valid;
	logic                         ready;
	logic [udmn_pkg::DataW-1:0]   divisor;

	modport source(output valid, output divisor, input ready);
	modport sink(input valid, input divisor, output ready);
endinterface

interface udmn_out_if;
	logic                         valid;
	logic                         ready;
	logic [udmn_pkg::DataW-1:0]   multiplier;
	logic                         add_flag;
	logic [udmn_pkg::ShiftW-1:0]  shift_amount;

	modport source(output valid, output multiplier, output add_flag, output shift_amount,
		input ready);
	modport sink(input valid, input multiplier, input add_flag, input shift_amount,
		output ready);
endinterface

@@ src/udmn_divider.sv @@
module udmn_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  udmn_pkg::div_req_t  req,
	output udmn_pkg::div_rsp_t  rsp
);

	logic [udmn_pkg::DataW-1:0]   n_q;
	logic [udmn_pkg::DataW-1:0]   r_q;
	logic [udmn_pkg::DataW-1:0]   d_q;
	logic [udmn_pkg::DivCntW-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [udmn_pkg::DataW:0]     trial;
	logic [udmn_pkg::DataW:0]     diff;
	logic                         ge;
	logic                         last;

	// Restoring division: one quotient bit per cycle. The dividend register
	// shifts out its top bit and takes the new quotient bit at the bottom.
	assign trial = {r_q, n_q[udmn_pkg::DataW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = (trial >= {1'b0, d_q});
	assign last  = (cnt_q == udmn_pkg::DivCntW'(udmn_pkg::DivSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			n_q <= {n_q[udmn_pkg::DataW-2:0], ge};
			r_q <= ge ? diff[udmn_pkg::DataW-1:0] : trial[udmn_pkg::DataW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = n_q;
	assign rsp.rem  = r_q;

endmodule

@@ src/udmn_refine.sv @@
module udmn_refine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udmn_pkg::ref_ctl_t   ctl,
	output udmn_pkg::ref_stat_t  stat
);

	logic [udmn_pkg::DataW-1:0] d_q;
	logic [udmn_pkg::DataW-1:0] nc_q;
	logic [udmn_pkg::DataW-1:0] q1_q;
	logic [udmn_pkg::DataW-1:0] r1_q;
	logic [udmn_pkg::DataW-1:0] q2_q;
	logic [udmn_pkg::DataW-1:0] r2_q;
	logic [udmn_pkg::PW-1:0]    p_q;
	logic                       over_q;
	logic                       addf_q;
	logic                       first_q;
	logic                       active_q;

	logic [udmn_pkg::DataW:0]   t1;
	logic [udmn_pkg::DataW:0]   t2;
	logic [udmn_pkg::DataW:0]   s1;
	logic [udmn_pkg::DataW:0]   s2;
	logic                       ge1;
	logic                       ge2;
	logic                       add_hit;
	logic [udmn_pkg::DataW-1:0] delta;
	logic                       more;
	logic                       done;
	logic                       step;
	logic [udmn_pkg::PW-1:0]    p_off;

	// The first remainder doubles each step and the second doubles plus one; the compares are done on 33 bits.
	assign t1  = {r1_q, 1'b0};
	assign t2  = {r2_q, 1'b1};
	assign s1  = t1 - {1'b0, nc_q};
	assign s2  = t2 - {1'b0, d_q};
	assign ge1 = (t1 >= {1'b0, nc_q});
	assign ge2 = (t2 >= {1'b0, d_q});
	assign add_hit = ge2 ? (q2_q >= udmn_pkg::TopLess) : (q2_q >= udmn_pkg::TopBit);

	// The exit test runs on the registered state after each step, in the same
	// cycle as the candidate next step, which is dropped when the test exits.
	assign delta = d_q - 1'b1 - r2_q;
	assign more  = (q1_q < delta) || ((q1_q == delta) && (r1_q == '0));
	assign done  = active_q && !first_q && ((p_q >= udmn_pkg::PLimit) || over_q || !more);
	assign step  = active_q && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			over_q   <= 1'b0;
			addf_q   <= 1'b0;
			p_q      <= '0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
			first_q  <= 1'b1;
			over_q   <= 1'b0;
			addf_q   <= 1'b0;
			p_q      <= udmn_pkg::PStart;
		end else if (ctl.release_res) begin
			active_q <= 1'b0;
		end else if (step) begin
			first_q <= 1'b0;
			p_q     <= p_q + 1'b1;
			over_q  <= over_q | q1_q[udmn_pkg::DataW-1];
			addf_q  <= addf_q | add_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q  <= ctl.d;
			nc_q <= ctl.nc;
			q1_q <= ctl.q1;
			r1_q <= ctl.r1;
			q2_q <= ctl.q2;
			r2_q <= ctl.r2;
		end else if (step) begin
			q1_q <= {q1_q[udmn_pkg::DataW-2:0], ge1};
			r1_q <= ge1 ? s1[udmn_pkg::DataW-1:0] : t1[udmn_pkg::DataW-1:0];
			q2_q <= {q2_q[udmn_pkg::DataW-2:0], ge2};
			r2_q <= ge2 ? s2[udmn_pkg::DataW-1:0] : t2[udmn_pkg::DataW-1:0];
		end
	end

	assign p_off      = p_q - udmn_pkg::PBias;
	assign stat.done  = done;
	assign stat.mult  = q2_q + 1'b1;
	assign stat.addf  = addf_q;
	assign stat.shift = p_off[udmn_pkg::ShiftW-1:0];

endmodule

@@ src/unsigned_div_magic_number.sv @@
// Magic-number generator for unsigned 32-bit division by a constant.
// The operand channel takes one divisor per request; the result channel
// returns the multiplier, the add flag and the post-shift for it. Both
// channels move a request at a clock edge where valid and ready are high.
// One divisor is processed at a time. A single bit-serial divider runs
// three 32-step divisions in turn (the remainder of -d by d, then 2^31 by
// nc, then 2^31-1 by d). The refinement unit then doubles both quotient/
// remainder pairs once per cycle, 1 to 33 steps, and checks the exit test
// on the registered state. The shared divider takes most of the time from
// acceptance to result valid. The block returns to idle at the edge that
// loads the result register, so the next divisor can be accepted while it is valid.
// The result sits in an output register; if the receiver stalls, a finished
// result waits in the refinement unit and the next divisor is accepted once
// the result register has been handed over. A zero divisor returns all-zero
// fields. Reset (arst_n low) empties the block and drops any pending result.
module unsigned_div_magic_number (
	input  logic        clk,
	input  logic        arst_n,
	udmn_in_if.sink     operand,
	udmn_out_if.source  result
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_NC   = 6'b000010,
		ST_Q1   = 6'b000100,
		ST_Q2   = 6'b001000,
		ST_REF  = 6'b010000,
		ST_HOLD = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	logic [udmn_pkg::DataW-1:0]  d_q;
	logic [udmn_pkg::DataW-1:0]  nc_q;
	logic [udmn_pkg::DataW-1:0]  q1_q;
	logic [udmn_pkg::DataW-1:0]  r1_q;
	logic [udmn_pkg::DataW-1:0]  mult_q;
	logic                        addf_q;
	logic [udmn_pkg::ShiftW-1:0] shift_q;
	logic                        out_valid_q;

	udmn_pkg::div_req_t  div_req;
	udmn_pkg::div_rsp_t  div_rsp;
	udmn_pkg::ref_ctl_t  ref_ctl;
	udmn_pkg::ref_stat_t ref_stat;

	logic accept;
	logic out_free;
	logic emit;
	logic d_zero;

	assign accept   = operand.valid && operand.ready;
	assign out_free = !out_valid_q || result.ready;
	assign emit     = ((state_q == ST_REF) && ref_stat.done && out_free) ||
		((state_q == ST_HOLD) && out_free);
	assign d_zero   = (d_q == '0);

	assign operand.ready = (state_q == ST_IDLE);

	udmn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	udmn_refine u_ref (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ref_ctl),
		.stat   (ref_stat)
	);

	always_comb begin
		state_nxt        = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = d_q;
		unique case (state_q)
			ST_IDLE: begin
				div_req.start    = accept;
				div_req.dividend = '0 - operand.divisor;
				div_req.divisor  = operand.divisor;
				if (accept) begin
					state_nxt = ST_NC;
				end
			end
			ST_NC: begin
				// nc is all ones minus the remainder, i.e. its complement.
				div_req.start    = div_rsp.done;
				div_req.dividend = udmn_pkg::TopBit;
				div_req.divisor  = ~div_rsp.rem;
				if (div_rsp.done) begin
					state_nxt = ST_Q1;
				end
			end
			ST_Q1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = udmn_pkg::TopLess;
				div_req.divisor  = d_q;
				if (div_rsp.done) begin
					state_nxt = ST_Q2;
				end
			end
			ST_Q2: begin
				if (div_rsp.done) begin
					state_nxt = ST_REF;
				end
			end
			ST_REF: begin
				if (ref_stat.done) begin
					state_nxt = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign ref_ctl.load        = (state_q == ST_Q2) && div_rsp.done;
	assign ref_ctl.release_res = emit;
	assign ref_ctl.d           = d_q;
	assign ref_ctl.nc          = nc_q;
	assign ref_ctl.q1          = q1_q;
	assign ref_ctl.r1          = r1_q;
	assign ref_ctl.q2          = div_rsp.quot;
	assign ref_ctl.r2          = div_rsp.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q <= operand.divisor;
		end
		if ((state_q == ST_NC) && div_rsp.done) begin
			nc_q <= ~div_rsp.rem;
		end
		if ((state_q == ST_Q1) && div_rsp.done) begin
			q1_q <= div_rsp.quot;
			r1_q <= div_rsp.rem;
		end
		if (emit) begin
			mult_q  <= d_zero ? '0 : ref_stat.mult;
			addf_q  <= d_zero ? 1'b0 : ref_stat.addf;
			shift_q <= d_zero ? '0 : ref_stat.shift;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.multiplier   = mult_q;
	assign result.add_flag     = addf_q;
	assign result.shift_amount = shift_q;

endmodule

@@ src/udmn_checker.sv @@
module udmn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [udmn_pkg::DataW-1:0]  out_multiplier,
	input logic                        out_add_flag,
	input logic [udmn_pkg::ShiftW-1:0] out_shift_amount
);

	// A stalled result keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_multiplier) && $stable(out_add_flag) &&
			$stable(out_shift_amount))
		else $error("result fields changed while stalled");

	// Only one divisor is in work: after a request the operand side closes.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("operand ready right after a request");

	// A result never appears the cycle after a divisor is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too soon after a request");

	// The post-shift never exceeds the word width.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_shift_amount <= udmn_pkg::ShiftW'(udmn_pkg::DataW))
		else $error("post-shift out of range");

endmodule

bind unsigned_div_magic_number udmn_checker u_udmn_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (operand.valid),
	.in_ready         (operand.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.out_multiplier   (result.multiplier),
	.out_add_flag     (result.add_flag),
	.out_shift_amount (result.shift_amount)
);
